[hdl/tsch_pkg.sv]
package tsch_pkg;

	localparam int TASK_SLOTS_DEF = 16;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [1:0] {
		CMD_INSTALL = 2'd0,
		CMD_DELAY = 2'd1,
		CMD_TICK = 2'd2,
		CMD_SCHED = 2'd3
	} tsch_cmd_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_FULL = 2'd1,
		ST_NONE = 2'd2
	} tsch_status_t;

	typedef enum logic [1:0] {
		OP_INSTALL,
		OP_TICK,
		OP_SWITCH
	} tsch_op_kind_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_TICK,
		S_PRIO,
		S_RR,
		S_FETCH,
		S_DONE
	} tsch_state_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic [31:0] stack_ptr;
		logic [7:0] task_prio;
		logic [31:0] delay_ticks;
	} tsch_in_t;

	typedef struct packed {
		logic [3:0] current_task;
		logic [31:0] next_stack;
		logic any_woken;
		logic [1:0] status;
	} tsch_out_t;

	typedef struct packed {
		tsch_op_kind_t op;
		logic delay;
		logic [31:0] stack_ptr;
		logic [7:0] task_prio;
		logic [31:0] delay_ticks;
	} tsch_op_t;

endpackage

[hdl/tsch_ram.sv]
module tsch_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hdl/tsch_front.sv]
module tsch_front (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input tsch_pkg::tsch_in_t item,
	input logic deq,
	output logic q_empty,
	output tsch_pkg::tsch_op_t q_item
);
	import tsch_pkg::*;

	tsch_op_t ent_q [QUEUE_DEPTH];
	tsch_op_t op_new;
	logic wr_q;
	logic rd_q;
	logic [1:0] cnt_q;
	logic do_push;
	logic do_pop;

	always_comb begin
		op_new.stack_ptr = item.stack_ptr;
		op_new.task_prio = item.task_prio;
		op_new.delay_ticks = item.delay_ticks;
		op_new.delay = (item.cmd == CMD_DELAY);
		case (item.cmd)
			CMD_INSTALL: op_new.op = OP_INSTALL;
			CMD_TICK: op_new.op = OP_TICK;
			default: op_new.op = OP_SWITCH;
		endcase
	end

	assign full = (cnt_q == 2'(QUEUE_DEPTH));
	assign q_empty = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop = deq && !q_empty;
	assign q_item = ent_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= !wr_q;
			end
			if (do_pop) begin
				rd_q <= !rd_q;
			end
			case ({do_push, do_pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_q] <= op_new;
		end
	end

endmodule

[hdl/tsch_back.sv]
module tsch_back #(
	parameter int TASK_SLOTS = tsch_pkg::TASK_SLOTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic sched_mode,
	input logic q_empty,
	input tsch_pkg::tsch_op_t q_item,
	output logic q_deq,
	output logic empty,
	input logic pop,
	output tsch_pkg::tsch_out_t result
);
	import tsch_pkg::*;

	localparam int IDX_W = $clog2(TASK_SLOTS);
	localparam int CNT_W = IDX_W + 1;

	tsch_state_t state_q, state_d;
	tsch_op_t op_q;
	tsch_status_t stat_q;
	tsch_out_t res_q;
	logic res_vld_q;
	logic [31:0] tick_q;
	logic [IDX_W-1:0] run_q;
	logic [IDX_W-1:0] best_q;
	logic [IDX_W-1:0] idx_s1;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] idx_q;
	logic [TASK_SLOTS-1:0] ready_q;
	logic [7:0] bprio_q;
	logic found_q;
	logic woken_q;
	logic vld_s1;

	logic res_free;
	logic full_tab;
	logic scan_more;
	logic [CNT_W-1:0] rr_sum;
	logic [IDX_W-1:0] rr_next;
	logic [IDX_W+3:0] run_ext;

	logic stk_we, stk_re;
	logic [IDX_W-1:0] stk_waddr, stk_raddr;
	logic [31:0] stk_rdata;
	logic pri_we, pri_re;
	logic [IDX_W-1:0] pri_raddr;
	logic [7:0] pri_rdata;
	logic wk_we, wk_re;
	logic [IDX_W-1:0] wk_waddr, wk_raddr;
	logic [31:0] wk_wdata, wk_rdata;

	tsch_ram #(.WIDTH(32), .DEPTH(TASK_SLOTS)) u_stack_ram (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(op_q.stack_ptr),
		.re(stk_re), .raddr(stk_raddr), .rdata(stk_rdata)
	);

	tsch_ram #(.WIDTH(8), .DEPTH(TASK_SLOTS)) u_prio_ram (
		.clk(clk), .we(pri_we), .waddr(count_q[IDX_W-1:0]), .wdata(op_q.task_prio),
		.re(pri_re), .raddr(pri_raddr), .rdata(pri_rdata)
	);

	tsch_ram #(.WIDTH(32), .DEPTH(TASK_SLOTS)) u_wake_ram (
		.clk(clk), .we(wk_we), .waddr(wk_waddr), .wdata(wk_wdata),
		.re(wk_re), .raddr(wk_raddr), .rdata(wk_rdata)
	);

	assign res_free = !res_vld_q || pop;
	assign full_tab = (count_q == CNT_W'(TASK_SLOTS));
	assign scan_more = (idx_q < count_q);
	assign rr_sum = {1'b0, best_q} + CNT_W'(1);
	assign rr_next = (rr_sum >= count_q) ? '0 : rr_sum[IDX_W-1:0];
	assign run_ext = {4'b0000, run_q};
	assign empty = !res_vld_q;
	assign result = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		q_deq = 1'b0;
		stk_we = 1'b0;
		stk_waddr = run_q;
		stk_re = 1'b0;
		stk_raddr = run_q;
		pri_we = 1'b0;
		pri_re = 1'b0;
		pri_raddr = idx_q[IDX_W-1:0];
		wk_we = 1'b0;
		wk_waddr = run_q;
		wk_wdata = '0;
		wk_re = 1'b0;
		wk_raddr = idx_q[IDX_W-1:0];
		case (state_q)
			S_IDLE: begin
				if (!q_empty) begin
					q_deq = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				case (op_q.op)
					OP_INSTALL: begin
						if (!full_tab) begin
							stk_we = 1'b1;
							stk_waddr = count_q[IDX_W-1:0];
							pri_we = 1'b1;
							wk_we = 1'b1;
							wk_waddr = count_q[IDX_W-1:0];
						end
						state_d = S_DONE;
					end
					OP_TICK: state_d = S_TICK;
					OP_SWITCH: begin
						stk_we = 1'b1;
						if (op_q.delay) begin
							wk_we = 1'b1;
							wk_wdata = tick_q + op_q.delay_ticks;
						end
						state_d = sched_mode ? S_PRIO : S_RR;
					end
					default: state_d = S_DONE;
				endcase
			end
			S_TICK: begin
				if (scan_more) begin
					wk_re = 1'b1;
				end else if (!vld_s1) begin
					state_d = S_DONE;
				end
			end
			S_PRIO: begin
				if (scan_more) begin
					pri_re = 1'b1;
				end else if (!vld_s1) begin
					state_d = S_FETCH;
				end
			end
			S_RR: begin
				if (!scan_more || ready_q[rr_next]) begin
					state_d = S_FETCH;
				end
			end
			S_FETCH: begin
				stk_re = 1'b1;
				stk_raddr = found_q ? best_q : run_q;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (res_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
			tick_q <= '0;
			run_q <= '0;
			count_q <= '0;
			ready_q <= '0;
			idx_q <= '0;
			found_q <= 1'b0;
			woken_q <= 1'b0;
			vld_s1 <= 1'b0;
			stat_q <= ST_OK;
		end else begin
			if (state_q == S_DONE && res_free) begin
				res_vld_q <= 1'b1;
			end else if (res_vld_q && pop) begin
				res_vld_q <= 1'b0;
			end
			case (state_q)
				S_EXEC: begin
					idx_q <= '0;
					vld_s1 <= 1'b0;
					found_q <= 1'b0;
					woken_q <= 1'b0;
					stat_q <= (op_q.op == OP_INSTALL && full_tab) ? ST_FULL : ST_OK;
					case (op_q.op)
						OP_INSTALL: begin
							if (!full_tab) begin
								ready_q[count_q[IDX_W-1:0]] <= 1'b1;
								count_q <= count_q + CNT_W'(1);
							end
						end
						OP_TICK: tick_q <= tick_q + 32'd1;
						OP_SWITCH: begin
							if (op_q.delay) begin
								ready_q[run_q] <= 1'b0;
							end
						end
						default: ;
					endcase
				end
				S_TICK, S_PRIO: begin
					if (scan_more) begin
						idx_q <= idx_q + CNT_W'(1);
					end
					vld_s1 <= scan_more;
					if (vld_s1) begin
						if (state_q == S_TICK) begin
							if (wk_rdata == tick_q) begin
								ready_q[idx_s1] <= 1'b1;
								woken_q <= 1'b1;
							end
						end else if (ready_q[idx_s1] && (!found_q || pri_rdata >= bprio_q)) begin
							found_q <= 1'b1;
						end
					end
				end
				S_RR: begin
					if (scan_more) begin
						idx_q <= idx_q + CNT_W'(1);
						if (ready_q[rr_next]) begin
							found_q <= 1'b1;
						end
					end
				end
				S_FETCH: begin
					if (found_q) begin
						run_q <= best_q;
					end else begin
						stat_q <= ST_NONE;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_deq) begin
			op_q <= q_item;
		end
		case (state_q)
			S_EXEC: best_q <= run_q;
			S_TICK, S_PRIO: begin
				idx_s1 <= idx_q[IDX_W-1:0];
				if (state_q == S_PRIO && vld_s1 && ready_q[idx_s1]
						&& (!found_q || pri_rdata >= bprio_q)) begin
					best_q <= idx_s1;
					bprio_q <= pri_rdata;
				end
			end
			S_RR: begin
				if (scan_more) begin
					best_q <= rr_next;
				end
			end
			S_DONE: begin
				if (res_free) begin
					res_q.current_task <= run_ext[3:0];
					res_q.next_stack <= (op_q.op == OP_SWITCH) ? stk_rdata : 32'd0;
					res_q.any_woken <= woken_q;
					res_q.status <= stat_q;
				end
			end
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TASK_SLOTS))
		else $error("Installed count exceeds the table size.");

	assert property (@(posedge clk) disable iff (!arst_n)
		run_q == '0 || {1'b0, run_q} < count_q)
		else $error("Running task lies outside the installed tasks.");

	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (state_q == S_TICK || state_q == S_PRIO))
		else $error("Scan data pending outside a table scan.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FETCH && found_q) |=> (stat_q == ST_OK && run_q == $past(best_q)))
		else $error("Selected task was not taken over.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && res_free) |=> (res_vld_q && state_q == S_IDLE))
		else $error("Finished command did not reach the result register.");

endmodule

[hdl/task_scheduler_with_tick_wakeup.sv]
// Task scheduler with a tick-driven wakeup. Commands enter through a two-entry
// queue, so up to two can be pushed while the previous one is still running or
// its result waits to be popped. Each command yields exactly one result, in
// order. Tick, delay and schedule walk the task table one slot per cycle; that
// table scan sets the rate. The scheduling mode register is written through
// cfg_we and cfg_data and should only change while no command is in flight.
module task_scheduler_with_tick_wakeup #(
	parameter int TASK_SLOTS = tsch_pkg::TASK_SLOTS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input tsch_pkg::tsch_in_t item,
	output logic empty,
	input logic pop,
	output tsch_pkg::tsch_out_t result,
	input logic cfg_we,
	input logic cfg_data
);
	import tsch_pkg::*;

	logic sched_mode_q;
	logic q_empty;
	logic q_deq;
	tsch_op_t q_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sched_mode_q <= 1'b0;
		end else if (cfg_we) begin
			sched_mode_q <= cfg_data;
		end
	end

	tsch_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.deq(q_deq),
		.q_empty(q_empty),
		.q_item(q_item)
	);

	tsch_back #(.TASK_SLOTS(TASK_SLOTS)) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.sched_mode(sched_mode_q),
		.q_empty(q_empty),
		.q_item(q_item),
		.q_deq(q_deq),
		.empty(empty),
		.pop(pop),
		.result(result)
	);

endmodule

[tb/tb_task_scheduler_with_tick_wakeup.sv]
`timescale 1ns / 100ps

module tb_task_scheduler_with_tick_wakeup;

	import tsch_pkg::*;

	localparam int SLOTS = TASK_SLOTS_DEF;

	typedef struct {
		logic is_cfg;
		logic cfg_val;
		tsch_in_t cmd_in;
		logic typed;
		tsch_out_t want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	tsch_in_t item = '0;
	logic empty;
	logic pop = 1'b0;
	tsch_out_t result;
	logic cfg_we = 1'b0;
	logic cfg_data = 1'b0;

	logic [31:0] task_stack [SLOTS];
	logic [7:0] task_prio_tab [SLOTS];
	logic slot_ready [SLOTS];
	logic [31:0] task_wake [SLOTS];
	int run_idx = 0;
	int n_tasks = 0;
	logic [31:0] tick_now = '0;
	logic prio_mode = 1'b0;

	tsch_out_t sched_results_q[$];
	tsch_out_t head;
	dir_row_t dir_rows[$];
	int idle_pct = 25;
	int errors = 0;

	task_scheduler_with_tick_wakeup DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.item(item),
		.empty(empty),
		.pop(pop),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("** task_scheduler_with_tick_wakeup: FAILED **");
		$finish;
	end

	task automatic flag_error(input string what);
		errors++;
		$display("mismatch at %0t ns: %s", $time, what);
	endtask

	function automatic tsch_status_t choose_task(input logic [31:0] stk);
		int slot;
		int probe;
		int best;
		logic hit;
		logic [7:0] top;
		task_stack[run_idx] = stk;
		hit = 1'b0;
		best = 0;
		top = '0;
		probe = run_idx;
		if (!prio_mode) begin
			for (slot = 0; slot < n_tasks && !hit; slot++) begin
				probe = probe + 1;
				if (probe >= n_tasks) begin
					probe = 0;
				end
				if (slot_ready[probe]) begin
					hit = 1'b1;
					best = probe;
				end
			end
		end else begin
			for (slot = 0; slot < n_tasks; slot++) begin
				if (slot_ready[slot] && (!hit || task_prio_tab[slot] >= top)) begin
					hit = 1'b1;
					top = task_prio_tab[slot];
					best = slot;
				end
			end
		end
		if (!hit) begin
			return ST_NONE;
		end
		run_idx = best;
		return ST_OK;
	endfunction

	function automatic tsch_out_t predict_sched(input tsch_in_t it);
		tsch_out_t o;
		int slot;
		o = '0;
		case (it.cmd)
			CMD_INSTALL: begin
				if (n_tasks >= SLOTS) begin
					o.status = ST_FULL;
				end else begin
					task_stack[n_tasks] = it.stack_ptr;
					task_prio_tab[n_tasks] = it.task_prio;
					slot_ready[n_tasks] = 1'b1;
					task_wake[n_tasks] = '0;
					n_tasks++;
				end
			end
			CMD_TICK: begin
				tick_now = tick_now + 32'd1;
				for (slot = 0; slot < n_tasks; slot++) begin
					if (task_wake[slot] == tick_now) begin
						slot_ready[slot] = 1'b1;
						o.any_woken = 1'b1;
					end
				end
			end
			default: begin
				if (it.cmd == CMD_DELAY) begin
					task_wake[run_idx] = tick_now + it.delay_ticks;
					slot_ready[run_idx] = 1'b0;
				end
				o.status = choose_task(it.stack_ptr);
				o.next_stack = task_stack[run_idx];
			end
		endcase
		o.current_task = 4'(run_idx);
		return o;
	endfunction

	function automatic tsch_in_t mk_cmd(input tsch_cmd_t c, input logic [31:0] stk,
			input logic [7:0] prio, input logic [31:0] dly);
		tsch_in_t it;
		it.cmd = c;
		it.stack_ptr = stk;
		it.task_prio = prio;
		it.delay_ticks = dly;
		return it;
	endfunction

	function automatic tsch_out_t mk_out(input logic [3:0] cur, input logic [31:0] nxt,
			input logic woken, input tsch_status_t st);
		tsch_out_t o;
		o.current_task = cur;
		o.next_stack = nxt;
		o.any_woken = woken;
		o.status = st;
		return o;
	endfunction

	function automatic void add_row(input logic is_cfg, input logic cfg_val,
			input tsch_in_t it, input logic typed, input tsch_out_t want);
		dir_row_t r;
		r.is_cfg = is_cfg;
		r.cfg_val = cfg_val;
		r.cmd_in = it;
		r.typed = typed;
		r.want = want;
		dir_rows.push_back(r);
	endfunction

	function automatic tsch_in_t rand_cmd();
		tsch_in_t it;
		int r;
		int k;
		r = $urandom_range(0, 99);
		k = $urandom_range(0, 99);
		it.stack_ptr = $urandom;
		it.task_prio = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(0, 255));
		it.delay_ticks = $urandom;
		if (r < 8) begin
			it.cmd = CMD_INSTALL;
		end else if (r < 33) begin
			it.cmd = CMD_DELAY;
			if (k == 0) begin
				it.delay_ticks = $urandom;
			end else if (k == 1) begin
				it.delay_ticks = '0;
			end else begin
				it.delay_ticks = $urandom_range(1, 8);
			end
		end else if (r < 68) begin
			it.cmd = CMD_TICK;
		end else begin
			it.cmd = CMD_SCHED;
		end
		return it;
	endfunction

	task automatic send_cmd(input tsch_in_t it, input logic typed, input tsch_out_t want);
		tsch_out_t calc;
		int gap;
		gap = 0;
		if ($urandom_range(0, 99) < idle_pct) begin
			gap = $urandom_range(1, 6);
		end
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		do @(posedge clk); while (full);
		calc = predict_sched(it);
		sched_results_q.push_back(typed ? want : calc);
	endtask

	task automatic drain();
		push <= 1'b0;
		while (sched_results_q.size() != 0) @(posedge clk);
	endtask

	task automatic write_mode(input logic m);
		cfg_we <= 1'b1;
		cfg_data <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		prio_mode = m;
	endtask

	always @(posedge clk) begin
		pop <= arst_n && ($urandom_range(0, 99) >= idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (sched_results_q.size() == 0) begin
				flag_error("result transfer with nothing expected");
			end else begin
				head = sched_results_q.pop_front();
				if (result.current_task !== head.current_task) begin
					flag_error($sformatf("current_task %0d, expected %0d",
						result.current_task, head.current_task));
				end
				if (result.next_stack !== head.next_stack) begin
					flag_error($sformatf("next_stack %h, expected %h",
						result.next_stack, head.next_stack));
				end
				if (result.any_woken !== head.any_woken) begin
					flag_error($sformatf("any_woken %b, expected %b",
						result.any_woken, head.any_woken));
				end
				if (result.status !== head.status) begin
					flag_error($sformatf("status %0d, expected %0d",
						result.status, head.status));
				end
			end
		end
	end

	initial begin
		int i;
		int ph;
		int k;
		for (i = 0; i < SLOTS; i++) begin
			slot_ready[i] = 1'b0;
			task_wake[i] = '0;
		end

		// An empty table leaves every switch on slot 0 with nothing ready.
		add_row(0, 0, mk_cmd(CMD_SCHED, 32'hA5A5_0001, 8'h00, 32'h0), 1,
			mk_out(4'd0, 32'hA5A5_0001, 1'b0, ST_NONE));
		add_row(0, 0, mk_cmd(CMD_DELAY, 32'h5A5A_0002, 8'h00, 32'd5), 1,
			mk_out(4'd0, 32'h5A5A_0002, 1'b0, ST_NONE));
		add_row(0, 0, mk_cmd(CMD_TICK, 32'h0, 8'h00, 32'h0), 1,
			mk_out(4'd0, 32'h0, 1'b0, ST_OK));
		for (i = 0; i < SLOTS; i++) begin
			add_row(0, 0, mk_cmd(CMD_INSTALL, (i == 0) ? 32'hFFFF_FFFF :
				(i == 1) ? 32'h0 : 32'h1000_0000 + 32'(i),
				(i % 3 == 0) ? 8'hFF : 8'(i % 4), 32'h0), 1,
				mk_out(4'd0, 32'h0, 1'b0, ST_OK));
		end
		add_row(0, 0, mk_cmd(CMD_INSTALL, 32'hDEAD_BEEF, 8'h7F, 32'h0), 1,
			mk_out(4'd0, 32'h0, 1'b0, ST_FULL));
		add_row(0, 0, mk_cmd(CMD_DELAY, 32'h2222_2222, 8'h00, 32'hFFFF_FFFF), 0, '0);
		add_row(0, 0, mk_cmd(CMD_DELAY, 32'h3333_3333, 8'h00, 32'd2), 0, '0);
		add_row(0, 0, mk_cmd(CMD_TICK, 32'h0, 8'h00, 32'h0), 0, '0);
		add_row(0, 0, mk_cmd(CMD_TICK, 32'h0, 8'h00, 32'h0), 0, '0);
		add_row(1, 1, '0, 0, '0);
		add_row(0, 0, mk_cmd(CMD_SCHED, 32'h4444_4444, 8'h00, 32'h0), 0, '0);
		add_row(0, 0, mk_cmd(CMD_DELAY, 32'h5555_5555, 8'h00, 32'h0), 0, '0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_mode(1'b0);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				drain();
				write_mode(dir_rows[i].cfg_val);
			end else begin
				send_cmd(dir_rows[i].cmd_in, dir_rows[i].typed, dir_rows[i].want);
			end
		end

		// The third phase runs with no idling on either side.
		for (ph = 0; ph < 6; ph++) begin
			drain();
			write_mode(ph % 2 == 1);
			idle_pct = (ph == 2) ? 0 : 25;
			for (k = 0; k < 190; k++) begin
				send_cmd(rand_cmd(), 1'b0, '0);
			end
		end

		drain();
		repeat (40) @(posedge clk);
		if (errors == 0 && sched_results_q.size() == 0) begin
			$display("** task_scheduler_with_tick_wakeup: PASSED **");
		end else begin
			$display("** task_scheduler_with_tick_wakeup: FAILED **");
		end
		$finish;
	end

endmodule

[sim.f]
hdl/tsch_pkg.sv
hdl/tsch_ram.sv
hdl/tsch_front.sv
hdl/tsch_back.sv
hdl/task_scheduler_with_tick_wakeup.sv
tb/tb_task_scheduler_with_tick_wakeup.sv
